### rtl/qhb_pkg.sv
// ----------------------------------------------------------------------------
// qhb_pkg: shared constants and types of the quad hit test
// Holds the radius width and reset value, the corner count and the result record.
// ----------------------------------------------------------------------------
package qhb_pkg;

  localparam int NUM_CORNERS     = 4;
  localparam int CORNER_IDX_BITS = 2;

  localparam int RADIUS_BITS = 12;
  localparam int RR_BITS     = 2 * RADIUS_BITS;

  // 18 px at 1/16 pixel resolution
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 12'd288;
  localparam logic [RR_BITS-1:0]     RR_RESET     =
      RR_BITS'(RADIUS_RESET) * RR_BITS'(RADIUS_RESET);

  typedef struct packed {
    logic                       handle_found;
    logic [CORNER_IDX_BITS-1:0] handle_index;
    logic                       body_hit;
  } qhb_result_t;

endpackage

### rtl/qhb_query_if.sv
// ----------------------------------------------------------------------------
// qhb_query_if: query channel
// Carries the point and the four corners, one query per transfer.
// ----------------------------------------------------------------------------
interface qhb_query_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] corner0_x;
  logic signed [COORD_BITS-1:0] corner0_y;
  logic signed [COORD_BITS-1:0] corner1_x;
  logic signed [COORD_BITS-1:0] corner1_y;
  logic signed [COORD_BITS-1:0] corner2_x;
  logic signed [COORD_BITS-1:0] corner2_y;
  logic signed [COORD_BITS-1:0] corner3_x;
  logic signed [COORD_BITS-1:0] corner3_y;

  modport source (
    output valid, point_x, point_y, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    output ready
  );
endinterface

### rtl/qhb_result_if.sv
// ----------------------------------------------------------------------------
// qhb_result_if: result channel
// Carries the handle and body classification, one result per transfer.
// ----------------------------------------------------------------------------
interface qhb_result_if;
  logic       valid;
  logic       ready;
  logic       handle_found;
  logic [1:0] handle_index;
  logic       body_hit;

  modport source (output valid, handle_found, handle_index, body_hit, input ready);
  modport sink   (input valid, handle_found, handle_index, body_hit, output ready);
endinterface

### rtl/qhb_cfg_if.sv
// ----------------------------------------------------------------------------
// qhb_cfg_if: configuration write channel
// Carries the handle radius, one write per transfer.
// ----------------------------------------------------------------------------
interface qhb_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/qhb_classify.sv
// ----------------------------------------------------------------------------
// qhb_classify: final compare stage
// Turns the registered products into handle and body decisions.
// ----------------------------------------------------------------------------
module qhb_classify import qhb_pkg::*; #(
  parameter int COORD_BITS = 20
) (
  input  logic signed [2*(COORD_BITS+1)-1:0] dsq_x_i [NUM_CORNERS],
  input  logic signed [2*(COORD_BITS+1)-1:0] dsq_y_i [NUM_CORNERS],
  input  logic signed [2*(COORD_BITS+3)-1:0] psq_x_i,
  input  logic signed [2*(COORD_BITS+3)-1:0] psq_y_i,
  input  logic signed [2*(COORD_BITS+3)-1:0] ksq_x_i [NUM_CORNERS],
  input  logic signed [2*(COORD_BITS+3)-1:0] ksq_y_i [NUM_CORNERS],
  input  logic signed [2*(COORD_BITS+1)-1:0] crs_l_i [NUM_CORNERS],
  input  logic signed [2*(COORD_BITS+1)-1:0] crs_r_i [NUM_CORNERS],
  input  logic        [RR_BITS-1:0]          rr_i,
  output qhb_result_t                        result_o
);

  localparam int PW = 2 * (COORD_BITS + 1);
  localparam int QW = 2 * (COORD_BITS + 3);

  logic signed [PW:0] rr_ext;
  logic signed [QW:0] pc;
  logic               hit  [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] pos;
  logic [NUM_CORNERS-1:0] neg;

  assign rr_ext = $signed({{(PW + 1 - RR_BITS){1'b0}}, rr_i});
  assign pc     = (QW+1)'(psq_x_i) + (QW+1)'(psq_y_i);

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
    logic signed [PW:0] dsq;
    logic signed [QW:0] kc;
    logic signed [PW:0] crs;

    assign dsq    = (PW+1)'(dsq_x_i[k]) + (PW+1)'(dsq_y_i[k]);
    assign kc     = (QW+1)'(ksq_x_i[k]) + (QW+1)'(ksq_y_i[k]);
    assign hit[k] = (dsq <= rr_ext) && (pc >= kc);
    assign crs    = (PW+1)'(crs_l_i[k]) - (PW+1)'(crs_r_i[k]);
    assign pos[k] = (crs > 0);
    assign neg[k] = (crs < 0);
  end

  // Lowest corner wins: scan from the top so the last match stands.
  always_comb begin
    result_o.handle_found = 1'b0;
    result_o.handle_index = '0;
    for (int k = NUM_CORNERS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        result_o.handle_found = 1'b1;
        result_o.handle_index = CORNER_IDX_BITS'(k);
      end
    end
    result_o.body_hit = (neg == '0) || (pos == '0);
  end

endmodule

### rtl/quad_handle_and_body_hit_test_unit.sv
// ----------------------------------------------------------------------------
// quad_handle_and_body_hit_test_unit: point versus quadrilateral classifier
// Reports the grabbed corner handle and whether the point is inside the body.
// ----------------------------------------------------------------------------
// Usage:
//   query_i  : point and four corners (signed, 1/16 pixel). A query transfers
//              when valid and ready are both high.
//   result_o : handle_found, handle_index and body_hit, one result per query,
//              in query order.
//   cfg_i    : handle radius write (12 bits, 1/16 pixel). Always ready; write
//              only while no query is in flight.
// Pipeline: a query passes through the four register stages in order:
//   differences, centroid offsets, products, compares into the output
//   register.
// Throughput: one query per cycle while result_o.ready stays high. Each of
//   the four register stages holds one query.
// Stalls: when result_o.ready is low the output register holds its result and
//   earlier stages keep filling bubbles; query_i.ready drops only once every
//   stage is occupied. Nothing is lost or repeated.
// Reset: the pipeline empties and the radius returns to 288 (18 px). The
//   radius is stored as its square, ready for the distance compare.
// ----------------------------------------------------------------------------
module quad_handle_and_body_hit_test_unit import qhb_pkg::*; #(
  parameter int COORD_BITS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  qhb_query_if.sink          query_i,
  qhb_result_if.source       result_o,
  qhb_cfg_if.sink            cfg_i
);

  localparam int DW = COORD_BITS + 1;   // point to corner difference
  localparam int EW = COORD_BITS + 3;   // centroid offsets, scaled by 4
  localparam int PW = 2 * DW;
  localparam int QW = 2 * EW;

  // --------------------------------------------------------------------------
  // Handshake: each stage advances when it is empty or its successor advances.
  // --------------------------------------------------------------------------
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, vo_q;

  assign en4 = !vo_q || result_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign query_i.ready = en1;
  assign cfg_i.ready   = 1'b1;

  // --------------------------------------------------------------------------
  // Radius register, kept squared
  // --------------------------------------------------------------------------
  logic [RR_BITS-1:0] rr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_q <= RR_RESET;
    end else if (cfg_i.valid) begin
      rr_q <= RR_BITS'(cfg_i.data) * RR_BITS'(cfg_i.data);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: point to corner differences and edge vectors
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] cx [NUM_CORNERS];
  logic signed [COORD_BITS-1:0] cy [NUM_CORNERS];

  assign cx[0] = query_i.corner0_x;
  assign cy[0] = query_i.corner0_y;
  assign cx[1] = query_i.corner1_x;
  assign cy[1] = query_i.corner1_y;
  assign cx[2] = query_i.corner2_x;
  assign cy[2] = query_i.corner2_y;
  assign cx[3] = query_i.corner3_x;
  assign cy[3] = query_i.corner3_y;

  logic signed [DW-1:0] dx1_q [NUM_CORNERS];
  logic signed [DW-1:0] dy1_q [NUM_CORNERS];
  logic signed [DW-1:0] ex1_q [NUM_CORNERS];
  logic signed [DW-1:0] ey1_q [NUM_CORNERS];

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_s1
    localparam int J = (k + 1) % NUM_CORNERS;
    always_ff @(posedge clk_i) begin
      if (en1) begin
        dx1_q[k] <= DW'(query_i.point_x) - DW'(cx[k]);
        dy1_q[k] <= DW'(query_i.point_y) - DW'(cy[k]);
        ex1_q[k] <= DW'(cx[J]) - DW'(cx[k]);
        ey1_q[k] <= DW'(cy[J]) - DW'(cy[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: centroid offsets. 4p - sum(c) is the sum of the differences, and
  // 4c_k - sum(c) is that value less four times difference k.
  // --------------------------------------------------------------------------
  logic signed [EW-1:0] pcx_d, pcy_d;
  logic signed [EW-1:0] pcx2_q, pcy2_q;
  logic signed [EW-1:0] kcx2_q [NUM_CORNERS];
  logic signed [EW-1:0] kcy2_q [NUM_CORNERS];
  logic signed [DW-1:0] dx2_q  [NUM_CORNERS];
  logic signed [DW-1:0] dy2_q  [NUM_CORNERS];
  logic signed [DW-1:0] ex2_q  [NUM_CORNERS];
  logic signed [DW-1:0] ey2_q  [NUM_CORNERS];

  assign pcx_d = (EW'(dx1_q[0]) + EW'(dx1_q[1])) + (EW'(dx1_q[2]) + EW'(dx1_q[3]));
  assign pcy_d = (EW'(dy1_q[0]) + EW'(dy1_q[1])) + (EW'(dy1_q[2]) + EW'(dy1_q[3]));

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pcx2_q <= pcx_d;
      pcy2_q <= pcy_d;
    end
  end

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_s2
    always_ff @(posedge clk_i) begin
      if (en2) begin
        kcx2_q[k] <= pcx_d - (EW'(dx1_q[k]) <<< 2);
        kcy2_q[k] <= pcy_d - (EW'(dy1_q[k]) <<< 2);
        dx2_q[k]  <= dx1_q[k];
        dy2_q[k]  <= dy1_q[k];
        ex2_q[k]  <= ex1_q[k];
        ey2_q[k]  <= ey1_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: products, each multiplier registered
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] dsq_x3_q [NUM_CORNERS];
  logic signed [PW-1:0] dsq_y3_q [NUM_CORNERS];
  logic signed [QW-1:0] ksq_x3_q [NUM_CORNERS];
  logic signed [QW-1:0] ksq_y3_q [NUM_CORNERS];
  logic signed [PW-1:0] crs_l3_q [NUM_CORNERS];
  logic signed [PW-1:0] crs_r3_q [NUM_CORNERS];
  logic signed [QW-1:0] psq_x3_q, psq_y3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      psq_x3_q <= QW'(pcx2_q) * QW'(pcx2_q);
      psq_y3_q <= QW'(pcy2_q) * QW'(pcy2_q);
    end
  end

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_s3
    always_ff @(posedge clk_i) begin
      if (en3) begin
        dsq_x3_q[k] <= PW'(dx2_q[k]) * PW'(dx2_q[k]);
        dsq_y3_q[k] <= PW'(dy2_q[k]) * PW'(dy2_q[k]);
        ksq_x3_q[k] <= QW'(kcx2_q[k]) * QW'(kcx2_q[k]);
        ksq_y3_q[k] <= QW'(kcy2_q[k]) * QW'(kcy2_q[k]);
        // (b - a) x (p - a) with p - a being this corner's difference
        crs_l3_q[k] <= PW'(ex2_q[k]) * PW'(dy2_q[k]);
        crs_r3_q[k] <= PW'(ey2_q[k]) * PW'(dx2_q[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: compares into the output register
  // --------------------------------------------------------------------------
  qhb_result_t res_d;
  qhb_result_t res_q;

  qhb_classify #(
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .dsq_x_i  (dsq_x3_q),
    .dsq_y_i  (dsq_y3_q),
    .psq_x_i  (psq_x3_q),
    .psq_y_i  (psq_y3_q),
    .ksq_x_i  (ksq_x3_q),
    .ksq_y_i  (ksq_y3_q),
    .crs_l_i  (crs_l3_q),
    .crs_r_i  (crs_r3_q),
    .rr_i     (rr_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (en4) begin
      res_q <= res_d;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= query_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) vo_q <= v3_q;
    end
  end

  assign result_o.valid        = vo_q;
  assign result_o.handle_found = res_q.handle_found;
  assign result_o.handle_index = res_q.handle_index;
  assign result_o.body_hit     = res_q.body_hit;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_index_zero_without_handle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    vo_q && !res_q.handle_found |-> res_q.handle_index == '0
  ) else $error("handle index set without a grabbed handle");

  a_query_enters_stage1: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    query_i.valid && query_i.ready |=> v1_q
  ) else $error("transferred query did not reach the first stage");

  a_stalled_stage3_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    v3_q && !en3 |=> v3_q
  ) else $error("stalled query dropped from the product stage");

endmodule

### sim/qhb_hit_checker.sv
// ----------------------------------------------------------------------------
// qhb_hit_checker: result checker of the quad hit test unit
// Watches the query, result and radius channels, predicts the classification
// of every accepted query and compares each result against it in order.
// ----------------------------------------------------------------------------
module qhb_hit_checker import qhb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  qhb_query_if        query_i,
  qhb_result_if       result_i,
  qhb_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int MAX_REPORTS = 10;

  // Wide enough for every product and sum at the coordinate width of the bench.
  typedef logic signed [127:0] wide_t;

  logic [RADIUS_BITS-1:0] radius;
  qhb_result_t            expected_q[$];
  qhb_result_t            want;
  wide_t                  pnt_x;
  wide_t                  pnt_y;
  wide_t                  crn_x[NUM_CORNERS];
  wide_t                  crn_y[NUM_CORNERS];
  int unsigned            fails;
  int unsigned            result_count;

  function automatic wide_t squared_len(wide_t dx, wide_t dy);
    return dx * dx + dy * dy;
  endfunction

  // Sign of (b - a) x (p - a).
  function automatic int edge_side(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                   wide_t px, wide_t py);
    wide_t turn;
    turn = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    if (turn < 0) return -1;
    if (turn > 0) return 1;
    return 0;
  endfunction

  function automatic qhb_result_t classify_point(wide_t px, wide_t py,
                                                 wide_t cx[NUM_CORNERS],
                                                 wide_t cy[NUM_CORNERS],
                                                 logic [RADIUS_BITS-1:0] rad);
    qhb_result_t res;
    wide_t       rad_w;
    wide_t       reach_sq;
    wide_t       sum_x;
    wide_t       sum_y;
    wide_t       point_spread;
    logic        all_pos;
    logic        all_neg;
    int          side;
    int          i;
    int          nxt;
    rad_w    = rad;
    reach_sq = rad_w * rad_w;
    sum_x    = 0;
    sum_y    = 0;
    for (i = 0; i < NUM_CORNERS; i++) begin
      sum_x += cx[i];
      sum_y += cy[i];
    end
    // Centroid distances are taken at four times scale.
    point_spread = squared_len(4 * px - sum_x, 4 * py - sum_y);
    res = '0;
    for (i = 0; i < NUM_CORNERS; i++) begin
      if (!res.handle_found && squared_len(px - cx[i], py - cy[i]) <= reach_sq &&
          point_spread >= squared_len(4 * cx[i] - sum_x, 4 * cy[i] - sum_y)) begin
        res.handle_found = 1'b1;
        res.handle_index = CORNER_IDX_BITS'(i);
      end
    end
    all_pos = 1'b1;
    all_neg = 1'b1;
    for (i = 0; i < NUM_CORNERS; i++) begin
      nxt  = (i + 1) % NUM_CORNERS;
      side = edge_side(cx[i], cy[i], cx[nxt], cy[nxt], px, py);
      if (side < 0) all_pos = 1'b0;
      if (side > 0) all_neg = 1'b0;
    end
    res.body_hit = all_pos | all_neg;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      radius = RADIUS_RESET;
      expected_q.delete();
      fails        = 0;
      result_count = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        radius = cfg_i.data;
      end

      if (result_i.valid && result_i.ready) begin
        result_count++;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("unexpected result %0d: found=%0b index=%0d body=%0b", result_count,
                     result_i.handle_found, result_i.handle_index, result_i.body_hit);
          end
        end else begin
          want = expected_q.pop_front();
          if (result_i.handle_found !== want.handle_found ||
              result_i.handle_index !== want.handle_index ||
              result_i.body_hit !== want.body_hit) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("result %0d: expected found=%0b index=%0d body=%0b, got found=%0b index=%0d body=%0b",
                       result_count, want.handle_found, want.handle_index, want.body_hit,
                       result_i.handle_found, result_i.handle_index, result_i.body_hit);
            end
          end
        end
      end

      if (query_i.valid && query_i.ready) begin
        pnt_x    = query_i.point_x;
        pnt_y    = query_i.point_y;
        crn_x[0] = query_i.corner0_x;
        crn_y[0] = query_i.corner0_y;
        crn_x[1] = query_i.corner1_x;
        crn_y[1] = query_i.corner1_y;
        crn_x[2] = query_i.corner2_x;
        crn_y[2] = query_i.corner2_y;
        crn_x[3] = query_i.corner3_x;
        crn_y[3] = query_i.corner3_y;
        expected_q.push_back(classify_point(pnt_x, pnt_y, crn_x, crn_y, radius));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
  end

endmodule

### sim/quad_handle_and_body_hit_test_unit_test.sv
// ----------------------------------------------------------------------------
// quad_handle_and_body_hit_test_unit_test: testbench of the quad hit test unit
// Runs directed corner and edge cases, then random queries under several
// radius settings with random gaps on the query and result channels. A
// checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module quad_handle_and_body_hit_test_unit_test;
  import qhb_pkg::*;

  localparam int          COORD_BITS       = 20;
  localparam int          COORD_MAX        = (1 << (COORD_BITS - 1)) - 1;
  localparam int          COORD_MIN        = -(1 << (COORD_BITS - 1));
  localparam int          RANDOM_PER_PHASE = 125;
  localparam int          NUM_PHASES       = 6;
  // Well past the latency of the unit.
  localparam int          DRAIN_CYCLES     = 8;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t                   px;
    coord_t                   py;
    coord_t [NUM_CORNERS-1:0] cx;
    coord_t [NUM_CORNERS-1:0] cy;
  } quad_query_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_HEAVY
  } idle_style_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  idle_style_e            idle_style   = IDLE_NONE;
  logic [RADIUS_BITS-1:0] radius_now   = RADIUS_RESET;
  int unsigned            cycle_count  = 0;
  int unsigned            stall_left;
  int unsigned            fail_count;
  int unsigned            pending;
  int                     phase;
  logic [RADIUS_BITS-1:0] phase_radius;

  qhb_query_if #(.COORD_BITS(COORD_BITS)) query ();
  qhb_result_if                           result ();
  qhb_cfg_if                              cfg ();

  quad_handle_and_body_hit_test_unit #(.COORD_BITS(COORD_BITS)) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .query_i  (query),
    .result_o (result),
    .cfg_i    (cfg)
  );

  qhb_hit_checker hit_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .query_i      (query),
    .result_i     (result),
    .cfg_i        (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (idle_style == IDLE_NONE) return 0;
    if (idle_style == IDLE_LIGHT) begin
      if (roll < 75) return 0;
      if (roll < 97) return $urandom_range(1, 2);
      return $urandom_range(3, 12);
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int rand_between(int lo, int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  // One coordinate from the edges of the range, around zero, or anywhere.
  function automatic int pick_special();
    case ($urandom_range(0, 5))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return int'($urandom());
    endcase
  endfunction

  function automatic quad_query_t make_quad(int px, int py, int c0x, int c0y, int c1x,
                                            int c1y, int c2x, int c2y, int c3x, int c3y);
    quad_query_t q;
    q.px    = coord_t'(px);
    q.py    = coord_t'(py);
    q.cx[0] = coord_t'(c0x);
    q.cy[0] = coord_t'(c0y);
    q.cx[1] = coord_t'(c1x);
    q.cy[1] = coord_t'(c1y);
    q.cx[2] = coord_t'(c2x);
    q.cy[2] = coord_t'(c2y);
    q.cx[3] = coord_t'(c3x);
    q.cy[3] = coord_t'(c3y);
    return q;
  endfunction

  // Axis-aligned rectangle, corners in clockwise screen order from top-left.
  function automatic quad_query_t axis_quad(int x0, int y0, int w, int h, int px, int py);
    return make_quad(px, py, x0, y0, x0 + w, y0, x0 + w, y0 + h, x0, y0 + h);
  endfunction

  function automatic quad_query_t rand_query();
    int unsigned kind;
    int unsigned roll;
    int          x0;
    int          y0;
    int          w;
    int          h;
    int          jit;
    int          reach;
    int          k;
    int          dx;
    int          dy;
    int          step;
    int          px;
    int          py;
    int          cx[NUM_CORNERS];
    int          cy[NUM_CORNERS];
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // Jittered rectangle with the cursor near a corner, inside, or around it.
      x0  = rand_between(-400000, 400000);
      y0  = rand_between(-400000, 400000);
      w   = ($urandom_range(0, 4) == 0) ? rand_between(1, 60000) : rand_between(1, 3000);
      h   = ($urandom_range(0, 4) == 0) ? rand_between(1, 60000) : rand_between(1, 3000);
      jit = ((w < h) ? w : h) / 8 + 1;
      cx[0] = x0 + rand_between(-jit, jit);
      cy[0] = y0 + rand_between(-jit, jit);
      cx[1] = x0 + w + rand_between(-jit, jit);
      cy[1] = y0 + rand_between(-jit, jit);
      cx[2] = x0 + w + rand_between(-jit, jit);
      cy[2] = y0 + h + rand_between(-jit, jit);
      cx[3] = x0 + rand_between(-jit, jit);
      cy[3] = y0 + h + rand_between(-jit, jit);
      reach = 2 * int'(radius_now) + 2;
      roll  = $urandom_range(0, 9);
      if (roll < 5) begin
        k  = $urandom_range(0, NUM_CORNERS - 1);
        px = cx[k] + rand_between(-reach, reach);
        py = cy[k] + rand_between(-reach, reach);
      end else if (roll < 8) begin
        px = rand_between(x0, x0 + w);
        py = rand_between(y0, y0 + h);
      end else begin
        px = rand_between(x0 - w, x0 + 2 * w);
        py = rand_between(y0 - h, y0 + 2 * h);
      end
      // Flip the winding now and then.
      if ($urandom_range(0, 3) == 0) begin
        return make_quad(px, py, cx[3], cy[3], cx[2], cy[2], cx[1], cy[1], cx[0], cy[0]);
      end
      return make_quad(px, py, cx[0], cy[0], cx[1], cy[1], cx[2], cy[2], cx[3], cy[3]);
    end else if (kind < 60) begin
      return make_quad(int'($urandom()), int'($urandom()), int'($urandom()),
                       int'($urandom()), int'($urandom()), int'($urandom()),
                       int'($urandom()), int'($urandom()), int'($urandom()),
                       int'($urandom()));
    end else if (kind < 72) begin
      // Collapsed corners or corners along one line.
      x0 = rand_between(-400000, 400000);
      y0 = rand_between(-400000, 400000);
      dx = 0;
      dy = 0;
      if ($urandom_range(0, 1) == 0) begin
        dx = rand_between(-64, 64);
        dy = rand_between(-64, 64);
      end
      for (k = 0; k < NUM_CORNERS; k++) begin
        step  = rand_between(-40, 40);
        cx[k] = x0 + step * dx;
        cy[k] = y0 + step * dy;
      end
      if ($urandom_range(0, 1) == 0) begin
        step = rand_between(-50, 50);
        px   = x0 + step * dx;
        py   = y0 + step * dy;
      end else begin
        px = x0 + rand_between(-300, 300);
        py = y0 + rand_between(-300, 300);
      end
      return make_quad(px, py, cx[0], cy[0], cx[1], cy[1], cx[2], cy[2], cx[3], cy[3]);
    end else if (kind < 88) begin
      return make_quad(rand_between(-512, 511), rand_between(-512, 511),
                       rand_between(-512, 511), rand_between(-512, 511),
                       rand_between(-512, 511), rand_between(-512, 511),
                       rand_between(-512, 511), rand_between(-512, 511),
                       rand_between(-512, 511), rand_between(-512, 511));
    end
    return make_quad(pick_special(), pick_special(), pick_special(), pick_special(),
                     pick_special(), pick_special(), pick_special(), pick_special(),
                     pick_special(), pick_special());
  endfunction

  // Offer one query after a random gap and hold it until it transfers. Keep
  // valid high across back-to-back queries.
  task automatic drive_query(input quad_query_t q);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      query.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    query.valid     <= 1'b1;
    query.point_x   <= q.px;
    query.point_y   <= q.py;
    query.corner0_x <= q.cx[0];
    query.corner0_y <= q.cy[0];
    query.corner1_x <= q.cx[1];
    query.corner1_y <= q.cy[1];
    query.corner2_x <= q.cx[2];
    query.corner2_y <= q.cy[2];
    query.corner3_x <= q.cx[3];
    query.corner3_y <= q.cy[3];
    do @(posedge clk_i); while (!query.ready);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline settle.
  task automatic drain_pipeline();
    query.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the radius only with the pipeline empty.
  task automatic write_radius(input logic [RADIUS_BITS-1:0] value);
    drain_pipeline();
    cfg.valid  <= 1'b1;
    cfg.data   <= value;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid  <= 1'b0;
    radius_now  = value;
  endtask

  // Result side: hold ready low for a random stall after each ready cycle.
  initial begin
    result.ready <= 1'b0;
    stall_left    = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        result.ready <= 1'b0;
        stall_left--;
      end else begin
        result.ready <= 1'b1;
        stall_left    = pick_gap();
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    query.valid     <= 1'b0;
    query.point_x   <= '0;
    query.point_y   <= '0;
    query.corner0_x <= '0;
    query.corner0_y <= '0;
    query.corner1_x <= '0;
    query.corner1_y <= '0;
    query.corner2_x <= '0;
    query.corner2_y <= '0;
    query.corner3_x <= '0;
    query.corner3_y <= '0;
    cfg.valid       <= 1'b0;
    cfg.data        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases at the reset radius of 18 px.
    idle_style = IDLE_LIGHT;
    drive_query(axis_quad(0, 0, 1600, 1600, 0, 0));        // exactly on corner 0
    drive_query(axis_quad(0, 0, 1600, 1600, 800, 800));    // centroid, no handle
    drive_query(axis_quad(0, 0, 1600, 1600, 1700, 1700));  // outside, near corner 2
    drive_query(axis_quad(0, 0, 1600, 1600, 1550, 1550));  // inside near corner 2
    drive_query(axis_quad(0, 0, 1600, 1600, 5000, -3000)); // far away
    drive_query(axis_quad(0, 0, 1600, 1600, 800, 0));      // on an edge
    // Counter-clockwise winding: all cross products non-positive.
    drive_query(make_quad(400, 400, 0, 0, 0, 1600, 1600, 1600, 1600, 0));
    // All corners coincide.
    drive_query(make_quad(100, 100, 100, 100, 100, 100, 100, 100, 100, 100));
    drive_query(make_quad(9000, 9000, 100, 100, 100, 100, 100, 100, 100, 100));
    // Corners and point on one line, then point off the line.
    drive_query(make_quad(50, 0, 0, 0, 300, 0, 700, 0, -200, 0));
    drive_query(make_quad(50, 40, 0, 0, 300, 0, 700, 0, -200, 0));
    // Two corners in reach: the lower index wins.
    drive_query(make_quad(50, -50, 0, 0, 100, 0, 100, 1600, 0, 1600));
    // Self-crossing outline.
    drive_query(make_quad(800, 400, 0, 0, 1600, 1600, 1600, 0, 0, 1600));
    // Range extremes.
    drive_query(make_quad(0, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX));
    drive_query(make_quad(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    drive_query(make_quad(COORD_MAX, COORD_MAX, COORD_MIN, -1, COORD_MIN, COORD_MIN,
                          -1, COORD_MIN, COORD_MAX, COORD_MIN));
    drive_query(axis_quad(-1600, -1600, 1600, 1600, 1, 1)); // just past corner 2

    // Zero radius: only an exact corner hit grabs.
    write_radius('0);
    drive_query(axis_quad(0, 0, 1600, 1600, 1600, 0));
    drive_query(axis_quad(0, 0, 1600, 1600, 1601, 0));

    // Largest radius.
    write_radius('1);
    drive_query(axis_quad(0, 0, 1600, 1600, -2500, -2500));
    drive_query(axis_quad(0, 0, 100, 100, -4000, 0));
    drive_query(make_quad(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                          COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX));

    // Random phases: sweep the radius and the amount of idling.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       phase_radius = RADIUS_BITS'(1);
        1:       phase_radius = '1;
        2:       phase_radius = '0;
        5:       phase_radius = RADIUS_RESET;
        default: phase_radius = RADIUS_BITS'($urandom_range(2, (1 << RADIUS_BITS) - 2));
      endcase
      write_radius(phase_radius);
      idle_style = idle_style_e'(phase % 3);
      repeat (RANDOM_PER_PHASE) drive_query(rand_query());
    end

    drain_pipeline();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/qhb_pkg.sv
rtl/qhb_query_if.sv
rtl/qhb_result_if.sv
rtl/qhb_cfg_if.sv
rtl/qhb_classify.sv
rtl/quad_handle_and_body_hit_test_unit.sv
sim/qhb_hit_checker.sv
sim/quad_handle_and_body_hit_test_unit_test.sv
